>>> src/assert_macros.svh
// Assertion macros used by the trial division prime test back end.
// No dependencies; take in with a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> src/tdp_pkg.sv
// Shared types and constants for the trial division prime test.
// No dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_DEF  = 4;

  // first odd trial divisor and the step between divisors
  localparam int FIRST_DIVISOR = 3;
  localparam int DIVISOR_STEP  = 2;

  // front verdict carried with each queued word
  typedef struct packed {
    logic needs_div;  // odd value above two, must be trial divided
    logic verdict;    // answer when no division is needed
  } class_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } back_state_t;

endpackage

>>> src/tdp_front.sv
// Front end: accepts input words and classifies them.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_front
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   q_full,
  output logic                   q_push,
  output class_t                 q_class
);

  logic neg;
  logic above_two;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // negatives, 0, 1 and even values settle at once; two is the only even prime
  assign neg               = value[VALUE_WIDTH-1];
  assign above_two         = !neg && (value > VALUE_WIDTH'(2));
  assign q_class.needs_div = above_two && value[0];
  assign q_class.verdict   = (value == VALUE_WIDTH'(2));

endmodule

>>> src/tdp_fifo.sv
// Short queue between front and back end, register based.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_fifo
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [VALUE_WIDTH-1:0] push_value,
  input  class_t                 push_class,
  input  logic                   pop,
  output logic [VALUE_WIDTH-1:0] head_value,
  output class_t                 head_class,
  output logic                   full,
  output logic                   empty
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] value_mem [FIFO_DEPTH];
  class_t                 class_mem [FIFO_DEPTH];
  logic [AW-1:0]          wr_ptr;
  logic [AW-1:0]          rd_ptr;
  logic [CW-1:0]          count;

  assign full       = (count == CW'(FIFO_DEPTH));
  assign empty      = (count == '0);
  assign head_value = value_mem[rd_ptr];
  assign head_class = class_mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      value_mem[wr_ptr] <= push_value;
      class_mem[wr_ptr] <= push_class;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/tdp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_div
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] diff;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {remainder, quotient[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      if (!diff[VALUE_WIDTH]) begin
        remainder <= diff[VALUE_WIDTH-1:0];
        quotient  <= {quotient[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[VALUE_WIDTH-1:0];
        quotient  <= {quotient[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  // step counter; done pulses once the last bit is in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        cnt  <= cnt - CW'(1);
        busy <= (cnt != CW'(1));
      end
    end
  end

endmodule

>>> src/tdp_back.sv
// Back end: runs trial division on queued words and holds the result word.
// Depends on tdp_pkg, tdp_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdp_back
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  class_t                 q_class,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_prime
);

  localparam logic [VALUE_WIDTH-1:0] DIV_FIRST = VALUE_WIDTH'(FIRST_DIVISOR);

  back_state_t            state;
  back_state_t            state_next;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] v_next;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] d_next;
  logic                   res;
  logic                   res_next;
  logic                   div_start;
  logic                   div_start_next;
  logic                   load_out;
  logic                   out_free;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rem;
  logic                   past_bound;

  tdp_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v),
    .divisor  (d),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  assign out_free   = !out_valid || out_ready;
  // d > v / d means d squared exceeds v: no divisor left to try
  assign past_bound = (d > quo);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = q_class.needs_div ? S_RUN : S_EMIT;
        end
      end
      S_RUN: begin
        if (div_done && (past_bound || rem == '0)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    q_pop          = 1'b0;
    v_next         = v;
    d_next         = d;
    res_next       = res;
    div_start_next = 1'b0;
    load_out       = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          v_next         = q_value;
          d_next         = DIV_FIRST;
          res_next       = q_class.verdict;
          div_start_next = q_class.needs_div;
        end
      end
      S_RUN: begin
        if (div_done) begin
          if (past_bound) begin
            res_next = 1'b1;
          end else if (rem == '0) begin
            res_next = 1'b0;
          end else begin
            d_next         = d + VALUE_WIDTH'(DIVISOR_STEP);
            div_start_next = 1'b1;
          end
        end
      end
      S_EMIT: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    v   <= v_next;
    d   <= d_next;
    res <= res_next;
    if (load_out) begin
      is_prime <= res;
    end
  end

  // control registers and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= div_start_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_done_in_run, clk, rst, div_done, state == S_RUN, "divider done outside run")
  `ASSERT_IMPLY(a_pop_in_idle, clk, rst, q_pop, state == S_IDLE, "queue popped while busy")
  `ASSERT_IMPLY(a_odd_divisor, clk, rst, state == S_RUN, d[0] && d >= DIV_FIRST, "bad divisor")
  `ASSERT_NEVER(a_start_busy, clk, rst, div_start && state != S_RUN, "divider started outside run")

endmodule

>>> src/trial_division_prime_test.sv
// Trial division prime test: one is_prime word for each value word.
// Negative, zero, one, two and even values take no trial division; an odd value above two
// is divided by successive odd divisors until one divides it or the square bound is passed.
// Worst case at 32 bits is 23170 trial divisors (divisors 3 to 46341).
// One value is worked at a time; the front queue keeps accepting while it has room.
// Synchronous active-high reset empties the queue and drops any pending result word.
`timescale 1ns / 1ps

module trial_division_prime_test
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_prime
);

  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;
  class_t                 push_class;
  class_t                 head_class;
  logic [VALUE_WIDTH-1:0] head_value;

  tdp_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value   (value),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_class (push_class)
  );

  tdp_fifo #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_value(value),
    .push_class(push_class),
    .pop       (q_pop),
    .head_value(head_value),
    .head_class(head_class),
    .full      (q_full),
    .empty     (q_empty)
  );

  tdp_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_value  (head_value),
    .q_class  (head_class),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_prime (is_prime)
  );

endmodule

>>> tb/trial_division_prime_test_tb.sv
// Self-checking testbench for trial_division_prime_test: directed edge and square bound
// values, back pressure and random value words, each verdict checked against a local predictor.
// Depends on tdp_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_tb;
  import tdp_pkg::*;

  localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 8;     // quick words pass the queue, state and out_valid registers
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   verdict;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [VALUE_WIDTH-1:0] value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   is_prime;

  verdict_t verdicts_due[$];
  verdict_t oldest_due;
  int       errors = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       hold_cycles = 0;
  int unsigned odd_factors[5] = '{3, 5, 7, 11, 13};

  trial_division_prime_test DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // primality by trial division over odd divisors, square bound kept exact
  function automatic logic prime_verdict(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] d;
    if (v[VALUE_WIDTH-1]) return 1'b0;
    if (v <= 2) return v == 2;
    if (!v[0]) return 1'b0;
    for (d = VALUE_WIDTH'(FIRST_DIVISOR); d <= v / d; d += VALUE_WIDTH'(DIVISOR_STEP)) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // offer one value word, optionally after a random gap, and log its verdict
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    int gap;
    verdict_t due;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due.value   = v;
    due.verdict = prime_verdict(v);
    verdicts_due.push_back(due);
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker: each is_prime word against the oldest verdict due
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected is_prime word, expected none, actual %0b", $time, is_prime);
        errors++;
      end else begin
        oldest_due = verdicts_due.pop_front();
        if (is_prime !== oldest_due.verdict) begin
          $display("%0t: is_prime for value %0d: expected %0b, actual %0b", $time,
                   $signed(oldest_due.value), oldest_due.verdict, is_prime);
          errors++;
        end
      end
    end
  end

  // sign bit, zero, one, two, smallest odd and even values, extremes of the range
  task automatic test_edge_values();
    logic [VALUE_WIDTH-1:0] edge_values[12];
    edge_values = '{32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd1, 32'd2,
                    32'd3, 32'd4, 32'd5, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555};
    foreach (edge_values[i]) send_value(edge_values[i]);
  endtask

  // odd values where the square bound decides: prime squares, products of two odd primes and larger primes
  task automatic test_square_bound();
    logic [VALUE_WIDTH-1:0] bound_values[9];
    bound_values = '{32'd9, 32'd15, 32'd25, 32'd49, 32'd169, 32'd64507, 32'd65521,
                     32'd1042441, 32'd1048573};
    foreach (bound_values[i]) send_value(bound_values[i]);
  endtask

  // receiver holds off while quick words pile up and the input stalls
  task automatic test_back_pressure();
    hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_value($urandom() | 32'h8000_0000);
      else send_value($urandom() & 32'h7FFF_FFFE);
    end
  endtask

  // random words, mostly small so the trial division stays short
  task automatic test_random_values(input int count);
    logic [VALUE_WIDTH-1:0] v;
    int unsigned pick;
    int unsigned p;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        v = $urandom_range(4095);
      end else if (pick < 60) begin
        v = $urandom() | 32'h8000_0000;
      end else if (pick < 75) begin
        v = $urandom() & 32'h7FFF_FFFE;
      end else if (pick < 93) begin
        // large multiple of a small odd prime: no divisor beyond that prime is tried
        p = odd_factors[$urandom_range(4)];
        v = p * $urandom_range(32'h7FFF_FFFF / p, 1);
      end else begin
        v = $urandom_range(65535) | 32'd1;
      end
      send_value(v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 76;
    test_edge_values();
    test_square_bound();
    test_random_values(22);

    tx_idle_pct = 76;
    rx_idle_pct = 38;
    test_random_values(22);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_back_pressure();
    test_random_values(23);

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("trial_division_prime_test_tb passed");
    end else begin
      $display("trial_division_prime_test_tb failed");
    end
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #10_000_000;
    $display("trial_division_prime_test_tb failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/tdp_pkg.sv
src/tdp_front.sv
src/tdp_fifo.sv
src/tdp_div.sv
src/tdp_back.sv
src/trial_division_prime_test.sv
tb/trial_division_prime_test_tb.sv
